### sv/owmt_pkg.sv
package owmt_pkg;

  localparam int COUNT_BITS = 10;
  localparam int BYTE_BITS  = 8;
  localparam int IDX_BITS   = $clog2(BYTE_BITS);

  localparam logic [COUNT_BITS-1:0] RESET_RELEASE_TIME  = COUNT_BITS'(30);
  localparam logic [COUNT_BITS-1:0] WRITE_ZERO_RECOVERY = COUNT_BITS'(5);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX           = '1;

  localparam logic [COUNT_BITS-1:0] RST_RESET_LOW_TIME      = COUNT_BITS'(500);
  localparam logic [COUNT_BITS-1:0] RST_PRESENCE_WAIT_LIMIT = COUNT_BITS'(100);
  localparam logic [COUNT_BITS-1:0] RST_PRESENCE_LOW_LIMIT  = COUNT_BITS'(240);
  localparam logic [COUNT_BITS-1:0] RST_SLOT_START_LOW      = COUNT_BITS'(10);
  localparam logic [COUNT_BITS-1:0] RST_READ_SAMPLE_DELAY   = COUNT_BITS'(2);
  localparam logic [COUNT_BITS-1:0] RST_READ_RECOVERY_TIME  = COUNT_BITS'(45);
  localparam logic [COUNT_BITS-1:0] RST_WRITE_ONE_HIGH_TIME = COUNT_BITS'(58);
  localparam logic [COUNT_BITS-1:0] RST_WRITE_ZERO_LOW_TIME = COUNT_BITS'(70);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_PRESENCE = 2'd1,
    ST_PRES_LONG   = 2'd2,
    ST_REFUSED     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_RESET_LOW_TIME      = 3'd0,
    REG_PRESENCE_WAIT_LIMIT = 3'd1,
    REG_PRESENCE_LOW_LIMIT  = 3'd2,
    REG_SLOT_START_LOW      = 3'd3,
    REG_READ_SAMPLE_DELAY   = 3'd4,
    REG_READ_RECOVERY_TIME  = 3'd5,
    REG_WRITE_ONE_HIGH_TIME = 3'd6,
    REG_WRITE_ZERO_LOW_TIME = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_REL   = 4'd2,
    PH_PRES_WAIT = 4'd3,
    PH_PRES_LOW  = 4'd4,
    PH_WR_LOW    = 4'd5,
    PH_WR_REL    = 4'd6,
    PH_RD_LOW    = 4'd7,
    PH_RD_WAIT   = 4'd8,
    PH_RD_REC    = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    RD_FROM_LOW    = 2'd0,
    RD_FROM_WAIT   = 2'd1,
    RD_FROM_SAMPLE = 2'd2
  } rd_mode_t;

  typedef struct packed {
    phase_t                phase;
    logic [IDX_BITS-1:0]   idx;
    logic [BYTE_BITS-1:0]  sb;
    logic                  fin;
  } slot_step_t;

  typedef struct packed {
    logic                  drive_low;
    logic                  busy_res;
    logic                  done_res;
    status_t               status;
    logic [BYTE_BITS-1:0]  read_data;
  } result_t;

  // enter a write slot at bit b, skipping slots of zero length
  function automatic slot_step_t wr_chain(
    input logic [IDX_BITS:0]   b,
    input logic [BYTE_BITS-1:0] sb,
    input logic                 one_zero_len,
    input logic                 ssl_nz,
    input logic                 wzl_nz
  );
    slot_step_t r;
    logic       found;
    r.phase = PH_IDLE;
    r.idx   = '0;
    r.sb    = sb;
    r.fin   = 1'b1;
    found   = 1'b0;
    for (int k = 0; k < BYTE_BITS; k++) begin
      if (!found && k >= int'(b) && !(sb[k] && one_zero_len)) begin
        found = 1'b1;
        r.idx = IDX_BITS'(k);
      end
    end
    if (found) begin
      r.fin = 1'b0;
      if (sb[r.idx] ? ssl_nz : wzl_nz) begin
        r.phase = PH_WR_LOW;
      end else begin
        r.phase = PH_WR_REL;
      end
    end
    return r;
  endfunction

  // enter a read slot part at bit b, skipping parts of zero length
  function automatic slot_step_t rd_chain(
    input rd_mode_t             mode,
    input logic [IDX_BITS:0]    b,
    input logic [BYTE_BITS-1:0] sb,
    input logic                 line,
    input logic                 ssl_nz,
    input logic                 rsd_nz,
    input logic                 rrt_nz
  );
    slot_step_t r;
    logic       do_sample;
    r.phase   = PH_IDLE;
    r.idx     = b[IDX_BITS-1:0];
    r.sb      = sb;
    r.fin     = 1'b0;
    do_sample = 1'b0;
    case (mode)
      RD_FROM_LOW: begin
        if (b[IDX_BITS]) begin
          r.fin = 1'b1;
        end else if (ssl_nz) begin
          r.phase = PH_RD_LOW;
        end else if (rsd_nz) begin
          r.phase = PH_RD_WAIT;
        end else begin
          do_sample = 1'b1;
        end
      end
      RD_FROM_WAIT: begin
        if (rsd_nz) begin
          r.phase = PH_RD_WAIT;
        end else begin
          do_sample = 1'b1;
        end
      end
      default: do_sample = 1'b1;
    endcase
    if (do_sample) begin
      r.sb[b[IDX_BITS-1:0]] = r.sb[b[IDX_BITS-1:0]] | line;
      if (rrt_nz) begin
        r.phase = PH_RD_REC;
      end else if (b[IDX_BITS-1:0] == IDX_BITS'(BYTE_BITS - 1)) begin
        r.fin = 1'b1;
      end else if (ssl_nz) begin
        r.phase = PH_RD_LOW;
        r.idx   = b[IDX_BITS-1:0] + 1'b1;
      end else if (rsd_nz) begin
        r.phase = PH_RD_WAIT;
        r.idx   = b[IDX_BITS-1:0] + 1'b1;
      end else begin
        for (int k = 0; k < BYTE_BITS; k++) begin
          if (k > int'(b)) begin
            r.sb[k] = r.sb[k] | line;
          end
        end
        r.fin = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

### sv/one_wire_master_timing.sv
// One-wire bus master stepped by microsecond ticks. Each input transaction is either a tick
// (carrying the bus level seen during the last microsecond) or a command (bus reset with
// presence detect, write byte, read byte; commands are taken only while idle, else refused
// with status 3). Every input transaction yields exactly one result transaction, registered
// in the output stage and held until the receiver takes it, holding the drive
// for the next microsecond, busy, done, status and the last byte read. One item per clock
// is sustained while the receiver keeps taking results: the whole step is a single pass from
// the accepted item and the phase counter into the result register, and a two-entry output
// stage keeps the input side ready while one result waits. The configuration port is always
// ready and is meant to be written while the block is idle.
module one_wire_master_timing (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // data_byte[7:0], line_level[8], zero
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // drive_low[0], busy_res[1], done_res[2], status[4:3],
                                  // read_data[12:5], zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam int CB = owmt_pkg::COUNT_BITS;
  localparam int BB = owmt_pkg::BYTE_BITS;
  localparam int IB = owmt_pkg::IDX_BITS;

  // configuration registers
  logic [CB-1:0] reset_low_time_r, presence_wait_limit_r, presence_low_limit_r;
  logic [CB-1:0] slot_start_low_r, read_sample_delay_r, read_recovery_time_r;
  logic [CB-1:0] write_one_high_time_r, write_zero_low_time_r;

  // bus state
  owmt_pkg::phase_t  phase_r, phase_nxt;
  logic [CB-1:0]     time_count_r, time_count_nxt;
  logic [IB-1:0]     bit_index_r, bit_index_nxt;
  logic [BB-1:0]     shift_byte_r, shift_byte_nxt;
  owmt_pkg::status_t last_status_r, last_status_nxt;
  logic [BB-1:0]     read_result_r, read_result_nxt;

  // output stage
  owmt_pkg::result_t out_r, skid_r, res;
  logic              out_valid_r, skid_valid_r;

  owmt_pkg::op_t     op;
  logic [BB-1:0]     data_byte;
  logic              line_level;
  logic              accept, take;

  logic              cur_bit;
  logic [CB-1:0]     dur, tc_inc;
  logic              ssl_nz, rsd_nz, rrt_nz, wzl_nz, w1h_nz;
  logic              done, refused;
  owmt_pkg::slot_step_t step;

  assign op         = owmt_pkg::op_t'(in_tuser);
  assign data_byte  = in_tdata[BB-1:0];
  assign line_level = in_tdata[BB];

  assign in_tready  = !skid_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign take       = out_valid_r && out_tready;
  assign cfg_ready  = 1'b1;

  assign ssl_nz  = slot_start_low_r != '0;
  assign rsd_nz  = read_sample_delay_r != '0;
  assign rrt_nz  = read_recovery_time_r != '0;
  assign wzl_nz  = write_zero_low_time_r != '0;
  assign w1h_nz  = write_one_high_time_r != '0;
  assign cur_bit = shift_byte_r[bit_index_r];
  assign tc_inc  = (time_count_r == owmt_pkg::COUNT_MAX) ? time_count_r
                                                         : time_count_r + 1'b1;

  always_comb begin
    case (phase_r)
      owmt_pkg::PH_RST_LOW: dur = reset_low_time_r;
      owmt_pkg::PH_RST_REL: dur = owmt_pkg::RESET_RELEASE_TIME;
      owmt_pkg::PH_WR_LOW:  dur = cur_bit ? slot_start_low_r : write_zero_low_time_r;
      owmt_pkg::PH_WR_REL:  dur = cur_bit ? write_one_high_time_r
                                          : owmt_pkg::WRITE_ZERO_RECOVERY;
      owmt_pkg::PH_RD_LOW:  dur = slot_start_low_r;
      owmt_pkg::PH_RD_WAIT: dur = read_sample_delay_r;
      owmt_pkg::PH_RD_REC:  dur = read_recovery_time_r;
      default:              dur = '0;
    endcase
  end

  always_comb begin
    phase_nxt       = phase_r;
    time_count_nxt  = time_count_r;
    bit_index_nxt   = bit_index_r;
    shift_byte_nxt  = shift_byte_r;
    last_status_nxt = last_status_r;
    read_result_nxt = read_result_r;
    done            = 1'b0;
    refused         = 1'b0;
    step            = '0;

    if (op == owmt_pkg::OP_TICK) begin
      case (phase_r)
        owmt_pkg::PH_PRES_WAIT: begin
          if (!line_level) begin
            phase_nxt      = owmt_pkg::PH_PRES_LOW;
            time_count_nxt = CB'(1);
            if (CB'(1) >= presence_low_limit_r) begin
              phase_nxt       = owmt_pkg::PH_IDLE;
              last_status_nxt = owmt_pkg::ST_PRES_LONG;
              done            = 1'b1;
            end
          end else begin
            time_count_nxt = tc_inc;
            if (tc_inc >= presence_wait_limit_r) begin
              phase_nxt       = owmt_pkg::PH_IDLE;
              last_status_nxt = owmt_pkg::ST_NO_PRESENCE;
              done            = 1'b1;
            end
          end
        end
        owmt_pkg::PH_PRES_LOW: begin
          if (line_level) begin
            phase_nxt       = owmt_pkg::PH_IDLE;
            time_count_nxt  = '0;
            last_status_nxt = owmt_pkg::ST_OK;
            done            = 1'b1;
          end else begin
            time_count_nxt = tc_inc;
            if (tc_inc >= presence_low_limit_r) begin
              phase_nxt       = owmt_pkg::PH_IDLE;
              last_status_nxt = owmt_pkg::ST_PRES_LONG;
              done            = 1'b1;
            end
          end
        end
        owmt_pkg::PH_IDLE: ;
        default: begin
          time_count_nxt = tc_inc;
          if (tc_inc >= dur) begin
            time_count_nxt = '0;
            case (phase_r)
              owmt_pkg::PH_RST_LOW: phase_nxt = owmt_pkg::PH_RST_REL;
              owmt_pkg::PH_RST_REL: phase_nxt = owmt_pkg::PH_PRES_WAIT;
              owmt_pkg::PH_WR_LOW: begin
                if (cur_bit && !w1h_nz) begin
                  step = owmt_pkg::wr_chain({1'b0, bit_index_r} + 1'b1, shift_byte_r,
                                            !ssl_nz, ssl_nz, wzl_nz);
                end else begin
                  step.phase = owmt_pkg::PH_WR_REL;
                  step.idx   = bit_index_r;
                  step.sb    = shift_byte_r;
                end
              end
              owmt_pkg::PH_WR_REL:
                step = owmt_pkg::wr_chain({1'b0, bit_index_r} + 1'b1, shift_byte_r,
                                          !ssl_nz && !w1h_nz, ssl_nz, wzl_nz);
              owmt_pkg::PH_RD_LOW:
                step = owmt_pkg::rd_chain(owmt_pkg::RD_FROM_WAIT, {1'b0, bit_index_r},
                                          shift_byte_r, line_level, ssl_nz, rsd_nz, rrt_nz);
              owmt_pkg::PH_RD_WAIT:
                step = owmt_pkg::rd_chain(owmt_pkg::RD_FROM_SAMPLE, {1'b0, bit_index_r},
                                          shift_byte_r, line_level, ssl_nz, rsd_nz, rrt_nz);
              default:
                step = owmt_pkg::rd_chain(owmt_pkg::RD_FROM_LOW, {1'b0, bit_index_r} + 1'b1,
                                          shift_byte_r, line_level, ssl_nz, rsd_nz, rrt_nz);
            endcase
            if (phase_r inside {owmt_pkg::PH_WR_LOW, owmt_pkg::PH_WR_REL,
                                owmt_pkg::PH_RD_LOW, owmt_pkg::PH_RD_WAIT,
                                owmt_pkg::PH_RD_REC}) begin
              bit_index_nxt  = step.idx;
              shift_byte_nxt = step.sb;
              if (step.fin) begin
                phase_nxt       = owmt_pkg::PH_IDLE;
                last_status_nxt = owmt_pkg::ST_OK;
                done            = 1'b1;
                if (phase_r inside {owmt_pkg::PH_RD_LOW, owmt_pkg::PH_RD_WAIT,
                                    owmt_pkg::PH_RD_REC}) begin
                  read_result_nxt = step.sb;
                end
              end else begin
                phase_nxt = step.phase;
              end
            end
          end
        end
      endcase
    end else if (phase_r != owmt_pkg::PH_IDLE) begin
      refused = 1'b1;
    end else begin
      last_status_nxt = owmt_pkg::ST_OK;
      bit_index_nxt   = '0;
      time_count_nxt  = '0;
      case (op)
        owmt_pkg::OP_RESET: begin
          phase_nxt = (reset_low_time_r != '0) ? owmt_pkg::PH_RST_LOW
                                               : owmt_pkg::PH_RST_REL;
        end
        owmt_pkg::OP_WRITE: begin
          step           = owmt_pkg::wr_chain('0, data_byte, !ssl_nz && !w1h_nz,
                                              ssl_nz, wzl_nz);
          shift_byte_nxt = data_byte;
          bit_index_nxt  = step.idx;
          phase_nxt      = step.fin ? owmt_pkg::PH_IDLE : step.phase;
          done           = step.fin;
        end
        default: begin
          step           = owmt_pkg::rd_chain(owmt_pkg::RD_FROM_LOW, '0, '0, line_level,
                                              ssl_nz, rsd_nz, rrt_nz);
          shift_byte_nxt = step.sb;
          bit_index_nxt  = step.idx;
          phase_nxt      = step.fin ? owmt_pkg::PH_IDLE : step.phase;
          done           = step.fin;
          if (step.fin) begin
            read_result_nxt = step.sb;
          end
        end
      endcase
    end

    res.drive_low = phase_nxt inside {owmt_pkg::PH_RST_LOW, owmt_pkg::PH_WR_LOW,
                                      owmt_pkg::PH_RD_LOW};
    res.busy_res  = phase_nxt != owmt_pkg::PH_IDLE;
    res.done_res  = done;
    res.status    = refused ? owmt_pkg::ST_REFUSED : last_status_nxt;
    res.read_data = read_result_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_low_time_r      <= owmt_pkg::RST_RESET_LOW_TIME;
      presence_wait_limit_r <= owmt_pkg::RST_PRESENCE_WAIT_LIMIT;
      presence_low_limit_r  <= owmt_pkg::RST_PRESENCE_LOW_LIMIT;
      slot_start_low_r      <= owmt_pkg::RST_SLOT_START_LOW;
      read_sample_delay_r   <= owmt_pkg::RST_READ_SAMPLE_DELAY;
      read_recovery_time_r  <= owmt_pkg::RST_READ_RECOVERY_TIME;
      write_one_high_time_r <= owmt_pkg::RST_WRITE_ONE_HIGH_TIME;
      write_zero_low_time_r <= owmt_pkg::RST_WRITE_ZERO_LOW_TIME;
    end else if (cfg_valid && cfg_ready) begin
      case (owmt_pkg::cfg_reg_t'(cfg_index))
        owmt_pkg::REG_RESET_LOW_TIME:      reset_low_time_r      <= cfg_data;
        owmt_pkg::REG_PRESENCE_WAIT_LIMIT: presence_wait_limit_r <= cfg_data;
        owmt_pkg::REG_PRESENCE_LOW_LIMIT:  presence_low_limit_r  <= cfg_data;
        owmt_pkg::REG_SLOT_START_LOW:      slot_start_low_r      <= cfg_data;
        owmt_pkg::REG_READ_SAMPLE_DELAY:   read_sample_delay_r   <= cfg_data;
        owmt_pkg::REG_READ_RECOVERY_TIME:  read_recovery_time_r  <= cfg_data;
        owmt_pkg::REG_WRITE_ONE_HIGH_TIME: write_one_high_time_r <= cfg_data;
        owmt_pkg::REG_WRITE_ZERO_LOW_TIME: write_zero_low_time_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= owmt_pkg::PH_IDLE;
      time_count_r  <= '0;
      bit_index_r   <= '0;
      shift_byte_r  <= '0;
      last_status_r <= owmt_pkg::ST_OK;
      read_result_r <= '0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      time_count_r  <= time_count_nxt;
      bit_index_r   <= bit_index_nxt;
      shift_byte_r  <= shift_byte_nxt;
      last_status_r <= last_status_nxt;
      read_result_r <= read_result_nxt;
    end
  end

  // result register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (accept) begin
      if (!out_valid_r || take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.read_data, out_r.status, out_r.done_res,
                       out_r.busy_res, out_r.drive_low};

endmodule

### tb/sv/one_wire_master_timing_check.sv
module one_wire_master_timing_check
  import owmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // data_byte[7:0], line_level[8], zero
  input  logic [1:0]  in_tuser,   // op[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // drive_low[0], busy_res[1], done_res[2], status[4:3],
                                  // read_data[12:5], zero
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  output int          outstanding,
  output logic        bus_busy,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SHOWN_MAX = 10;

  logic [COUNT_BITS-1:0] timing [8];
  phase_t                phase;
  logic [COUNT_BITS-1:0] elapsed;
  logic [IDX_BITS-1:0]   bit_pos;
  logic [BYTE_BITS-1:0]  shreg;
  logic [BYTE_BITS-1:0]  rd_byte;
  status_t               last_st;
  logic                  fin_flag;
  result_t               due_results [$];
  int                    mismatches = 0;

  function automatic logic timed(input phase_t ph);
    return ph == PH_RST_LOW || ph == PH_RST_REL || ph >= PH_WR_LOW;
  endfunction

  function automatic logic [COUNT_BITS-1:0] span(input phase_t ph);
    case (ph)
      PH_RST_LOW: return timing[REG_RESET_LOW_TIME];
      PH_RST_REL: return RESET_RELEASE_TIME;
      PH_WR_LOW:
        return shreg[bit_pos] ? timing[REG_SLOT_START_LOW] : timing[REG_WRITE_ZERO_LOW_TIME];
      PH_WR_REL:
        return shreg[bit_pos] ? timing[REG_WRITE_ONE_HIGH_TIME] : WRITE_ZERO_RECOVERY;
      PH_RD_LOW:  return timing[REG_SLOT_START_LOW];
      PH_RD_WAIT: return timing[REG_READ_SAMPLE_DELAY];
      PH_RD_REC:  return timing[REG_READ_RECOVERY_TIME];
      default:    return '0;
    endcase
  endfunction

  function automatic phase_t wrap_up(input status_t st);
    last_st = st;
    fin_flag = 1'b1;
    return PH_IDLE;
  endfunction

  // what follows the end of a timed phase
  function automatic phase_t close_phase(input phase_t ph, input logic lvl);
    case (ph)
      PH_RST_LOW: return PH_RST_REL;
      PH_RST_REL: return PH_PRES_WAIT;
      PH_WR_LOW:  return PH_WR_REL;
      PH_WR_REL: begin
        if (bit_pos == IDX_BITS'(BYTE_BITS - 1)) return wrap_up(ST_OK);
        bit_pos = bit_pos + 1'b1;
        return PH_WR_LOW;
      end
      PH_RD_LOW:  return PH_RD_WAIT;
      PH_RD_WAIT: begin
        shreg[bit_pos] = shreg[bit_pos] | lvl;
        return PH_RD_REC;
      end
      PH_RD_REC: begin
        if (bit_pos == IDX_BITS'(BYTE_BITS - 1)) begin
          rd_byte = shreg;
          return wrap_up(ST_OK);
        end
        bit_pos = bit_pos + 1'b1;
        return PH_RD_LOW;
      end
      default: return PH_IDLE;
    endcase
  endfunction

  // zero-length phases fall through within the same transaction
  function automatic void open_phase(input phase_t ph, input logic lvl);
    phase_t nxt;
    nxt = ph;
    while (1'b1) begin
      phase = nxt;
      elapsed = '0;
      if (!timed(nxt) || span(nxt) != '0) return;
      nxt = close_phase(nxt, lvl);
    end
  endfunction

  function automatic void advance_us(input logic lvl);
    if (phase == PH_PRES_WAIT) begin
      if (!lvl) begin
        phase = PH_PRES_LOW;
        elapsed = COUNT_BITS'(1);
        if (elapsed >= timing[REG_PRESENCE_LOW_LIMIT]) phase = wrap_up(ST_PRES_LONG);
      end else begin
        if (elapsed != COUNT_MAX) elapsed = elapsed + 1'b1;
        if (elapsed >= timing[REG_PRESENCE_WAIT_LIMIT]) phase = wrap_up(ST_NO_PRESENCE);
      end
    end else if (phase == PH_PRES_LOW) begin
      if (lvl) begin
        phase = wrap_up(ST_OK);
        elapsed = '0;
      end else begin
        if (elapsed != COUNT_MAX) elapsed = elapsed + 1'b1;
        if (elapsed >= timing[REG_PRESENCE_LOW_LIMIT]) phase = wrap_up(ST_PRES_LONG);
      end
    end else if (timed(phase)) begin
      if (elapsed != COUNT_MAX) elapsed = elapsed + 1'b1;
      if (elapsed >= span(phase)) open_phase(close_phase(phase, lvl), lvl);
    end
  endfunction

  function automatic result_t bus_step(input op_t op, input logic [BYTE_BITS-1:0] payload,
                                       input logic lvl);
    result_t r;
    logic    refused;
    fin_flag = 1'b0;
    refused = 1'b0;
    if (op == OP_TICK) begin
      advance_us(lvl);
    end else if (phase != PH_IDLE) begin
      refused = 1'b1;
    end else begin
      last_st = ST_OK;
      bit_pos = '0;
      case (op)
        OP_RESET: open_phase(PH_RST_LOW, lvl);
        OP_WRITE: begin
          shreg = payload;
          open_phase(PH_WR_LOW, lvl);
        end
        default: begin
          shreg = '0;
          open_phase(PH_RD_LOW, lvl);
        end
      endcase
    end
    r.drive_low = phase == PH_RST_LOW || phase == PH_WR_LOW || phase == PH_RD_LOW;
    r.busy_res  = phase != PH_IDLE;
    r.done_res  = fin_flag;
    r.status    = refused ? ST_REFUSED : last_st;
    r.read_data = rd_byte;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (!rst_n) begin
      timing[REG_RESET_LOW_TIME]      = RST_RESET_LOW_TIME;
      timing[REG_PRESENCE_WAIT_LIMIT] = RST_PRESENCE_WAIT_LIMIT;
      timing[REG_PRESENCE_LOW_LIMIT]  = RST_PRESENCE_LOW_LIMIT;
      timing[REG_SLOT_START_LOW]      = RST_SLOT_START_LOW;
      timing[REG_READ_SAMPLE_DELAY]   = RST_READ_SAMPLE_DELAY;
      timing[REG_READ_RECOVERY_TIME]  = RST_READ_RECOVERY_TIME;
      timing[REG_WRITE_ONE_HIGH_TIME] = RST_WRITE_ONE_HIGH_TIME;
      timing[REG_WRITE_ZERO_LOW_TIME] = RST_WRITE_ZERO_LOW_TIME;
      phase    = PH_IDLE;
      elapsed  = '0;
      bit_pos  = '0;
      shreg    = '0;
      rd_byte  = '0;
      last_st  = ST_OK;
      fin_flag = 1'b0;
      due_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.drive_low = out_tdata[0];
        got.busy_res  = out_tdata[1];
        got.done_res  = out_tdata[2];
        got.status    = status_t'(out_tdata[4:3]);
        got.read_data = out_tdata[12:5];
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MAX)
            $display("%0t: unexpected result transaction %h", $time, out_tdata);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= SHOWN_MAX) begin
              $display("%0t: result mismatch, expected drive=%0b busy=%0b done=%0b status=%0d read=%h",
                       $time, want.drive_low, want.busy_res, want.done_res, want.status,
                       want.read_data);
              $display("%0t: result mismatch, got      drive=%0b busy=%0b done=%0b status=%0d read=%h",
                       $time, got.drive_low, got.busy_res, got.done_res, got.status,
                       got.read_data);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) timing[cfg_index] = cfg_data;
      if (in_tvalid && in_tready)
        due_results.push_back(bus_step(op_t'(in_tuser), in_tdata[7:0], in_tdata[8]));
    end
    outstanding <= due_results.size();
    bus_busy    <= phase != PH_IDLE;
    fail_count  <= mismatches;
  end

endmodule

### tb/sv/one_wire_master_timing_test.sv
module one_wire_master_timing_test;
  import owmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 60;
  localparam logic [7:0] READ_PATTERN = 8'h4D;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = OP_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_RESET_LOW_TIME;
  logic [9:0]  cfg_data = '0;

  int   outstanding;
  logic bus_busy;
  int   fail_count;
  int   cycle_count = 0;
  logic steady = 1'b0;
  logic hold_req = 1'b0;
  logic [COUNT_BITS-1:0] timing_plan [8];

  always #1 clk = ~clk;

  one_wire_master_timing i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  one_wire_master_timing_check i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .bus_busy    (bus_busy),
    .fail_count  (fail_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side, with an occasional long hold-off
  initial begin
    int   gap;
    logic hold_seen;
    hold_seen = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic push_item(input op_t op, input logic [7:0] payload, input logic lvl);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, lvl, payload};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic tick_run(input int n, input logic lvl);
    repeat (n) push_item(OP_TICK, 8'($urandom), lvl);
  endtask

  // tick until the bus master is idle and every result is in
  task automatic drain_bus();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    while (bus_busy) begin
      while (bus_busy) push_item(OP_TICK, 8'($urandom), 1'($urandom));
      in_tvalid <= 1'b0;
      do @(posedge clk); while (outstanding != 0);
    end
  endtask

  task automatic write_timing();
    for (int r = 0; r < 8; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(r);
      cfg_data  <= timing_plan[r];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int n, input int lo, input int hi, input int low_pct,
                            input logic stall);
    op_t op;
    foreach (timing_plan[r]) timing_plan[r] = COUNT_BITS'($urandom_range(lo, hi));
    write_timing();
    steady = $urandom_range(0, 2) == 0;
    for (int k = 0; k < n; k++) begin
      if (stall && k == n / 2) hold_req = ~hold_req;
      if (bus_busy)
        op = ($urandom_range(0, 19) == 0) ? op_t'($urandom_range(1, 3)) : OP_TICK;
      else
        op = ($urandom_range(0, 9) < 7) ? op_t'($urandom_range(1, 3)) : OP_TICK;
      push_item(op, 8'($urandom), $urandom_range(0, 99) >= low_pct);
    end
    drain_bus();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // timings as after reset
    push_item(OP_TICK, 8'h00, 1'b0);
    push_item(OP_WRITE, 8'h3C, 1'b1);
    drain_bus();

    // short timings: presence outcomes, refusal, slot sampling
    timing_plan = '{10'd1, 10'd3, 10'd4, 10'd1, 10'd0, 10'd0, 10'd0, 10'd1};
    write_timing();
    tick_run(1, 1'b0);
    tick_run(1, 1'b1);
    push_item(OP_RESET, 8'h00, 1'b1);
    push_item(OP_READ, 8'h00, 1'b1);
    tick_run(31, 1'b1);
    tick_run(2, 1'b1);
    tick_run(2, 1'b0);
    tick_run(1, 1'b1);
    tick_run(1, 1'b0);
    push_item(OP_RESET, 8'hFF, 1'b0);
    tick_run(34, 1'b1);
    push_item(OP_RESET, 8'h00, 1'b1);
    tick_run(31, 1'b1);
    tick_run(4, 1'b0);
    push_item(OP_WRITE, 8'hA5, 1'b0);
    drain_bus();
    push_item(OP_WRITE, 8'h00, 1'b1);
    drain_bus();
    push_item(OP_WRITE, 8'hFF, 1'b0);
    drain_bus();
    push_item(OP_READ, 8'h00, 1'b0);
    for (int k = 0; k < 8; k++) push_item(OP_TICK, 8'($urandom), READ_PATTERN[k]);
    drain_bus();

    // zero timings: phases pass within one transaction, limits fail at once
    foreach (timing_plan[r]) timing_plan[r] = '0;
    write_timing();
    push_item(OP_WRITE, 8'hFF, 1'b0);
    push_item(OP_READ, 8'h00, 1'b1);
    push_item(OP_READ, 8'hFF, 1'b0);
    push_item(OP_WRITE, 8'h00, 1'b1);
    push_item(OP_RESET, 8'h00, 1'b1);
    push_item(OP_WRITE, 8'h55, 1'b0);
    drain_bus();
    push_item(OP_RESET, 8'h00, 1'b1);
    tick_run(31, 1'b1);
    push_item(OP_RESET, 8'h00, 1'b0);
    tick_run(30, 1'b1);
    tick_run(1, 1'b0);
    push_item(OP_WRITE, 8'h81, 1'b1);
    drain_bus();

    // longest timings
    foreach (timing_plan[r]) timing_plan[r] = COUNT_MAX;
    write_timing();
    steady = 1'b1;
    push_item(OP_RESET, 8'h00, 1'b0);
    drain_bus();

    run_random(100, 0, 3, 50, 1'b0);
    run_random(100, 1, 8, 30, 1'b1);
    run_random(100, 0, 20, 70, 1'b0);
    run_random(100, 2, 6, 50, 1'b0);
    run_random(100, 0, 1, 20, 1'b0);

    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
sv/owmt_pkg.sv
sv/one_wire_master_timing.sv
tb/sv/one_wire_master_timing_check.sv
tb/sv/one_wire_master_timing_test.sv
